// ===== hw/rtl/itm_pkg.sv =====
// Shared constants, types and control structs of the interval throughput meter.
package itm_pkg;

    localparam longint unsigned TICKS_PER_SECOND = 64'd1000000;
    localparam int MAX_REPORTS = 64;

    localparam int TIME_W    = 48;
    localparam int BYTE_W    = 40;
    localparam int PKT_W     = 32;
    localparam int IVL_W     = 32;
    localparam int LEN_W     = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam int TPS_W   = $clog2(TICKS_PER_SECOND + 64'd1);
    localparam int PROD_W  = BYTE_W + 3 + TPS_W;
    localparam int DIV_W   = (PROD_W > TIME_W) ? PROD_W : TIME_W;
    localparam int QEXT_W  = (DIV_W > TIME_W + 1) ? DIV_W : TIME_W + 1;
    localparam int DCNT_W  = $clog2(DIV_W);
    localparam int NRES_W  = $clog2(MAX_REPORTS + 1);
    localparam int SPAN_W  = IVL_W + $clog2(MAX_REPORTS + 2);
    localparam int BSUM_W  = ((TIME_W > SPAN_W) ? TIME_W : SPAN_W) + 1;

    localparam logic [IVL_W-1:0] IVL_RESET   = IVL_W'(1000000);
    localparam logic [PKT_W-1:0] LIMIT_RESET = PKT_W'(100);
    localparam logic             ZMODE_RESET = 1'b1;

    localparam logic [TIME_W-1:0] RATE_MAX = {TIME_W{1'b1}};

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERVAL = 2'd0,
        CFG_LIMIT    = 2'd1,
        CFG_ZMODE    = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        END_NOW   = 2'd0,
        END_BND   = 2'd1,
        END_CATCH = 2'd2
    } end_sel_t;

    typedef struct packed {
        logic     accept;
        logic     add_bytes;
        logic     eval_cut;
        logic     load_end;
        end_sel_t end_sel;
        logic     rate_start;
        logic     jump_start;
        logic     div_step;
        logic     rep_commit;
        logic     jump_commit;
        logic     push;
        logic     push_last;
    } itm_cmd_t;

    typedef struct packed {
        logic cmd;
        logic zmode;
        logic limit_hit;
        logic bnd_le;
        logic bnd_lt;
        logic last_lt_now;
        logic cap_pkt;
        logic cap_fin;
        logic need_div;
        logic div_last;
        logic out_free;
        logic cut;
        logic ivl_zero;
    } itm_sts_t;

endpackage

// ===== hw/rtl/itm_div.sv =====
// Restoring divider, one quotient bit per step, shared by rate and boundary jump.
module itm_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic                      step,
    input  logic [itm_pkg::DIV_W-1:0]  dividend,
    input  logic [itm_pkg::TIME_W-1:0] divisor,
    output logic [itm_pkg::DIV_W-1:0]  quotient,
    output logic [itm_pkg::TIME_W-1:0] remainder,
    output logic                      last_step
);

    logic [itm_pkg::TIME_W-1:0] rem_reg;
    logic [itm_pkg::TIME_W-1:0] rem_next;
    logic [itm_pkg::DIV_W-1:0]  dvd_reg;
    logic [itm_pkg::DIV_W-1:0]  dvd_next;
    logic [itm_pkg::TIME_W-1:0] dsr_reg;
    logic [itm_pkg::DCNT_W-1:0] cnt_reg;
    logic [itm_pkg::TIME_W:0]   shifted;
    logic [itm_pkg::TIME_W:0]   sub;
    logic                      ge;

    assign shifted   = {rem_reg, dvd_reg[itm_pkg::DIV_W-1]};
    assign sub       = shifted - {1'b0, dsr_reg};
    assign ge        = shifted >= {1'b0, dsr_reg};
    assign rem_next  = ge ? sub[itm_pkg::TIME_W-1:0] : shifted[itm_pkg::TIME_W-1:0];
    assign dvd_next  = {dvd_reg[itm_pkg::DIV_W-2:0], ge};
    assign last_step = cnt_reg == itm_pkg::DCNT_W'(itm_pkg::DIV_W - 1);
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= '0;
        end
        else if (step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

endmodule

// ===== hw/rtl/itm_dpath.sv =====
// Datapath: configuration, counters, report time, rate division and output word register.
module itm_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [itm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [itm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                         command,
    input  logic [itm_pkg::TIME_W-1:0]    now_time,
    input  logic [itm_pkg::LEN_W-1:0]     packet_bytes,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic [itm_pkg::TIME_W-1:0]    report_time,
    output logic [itm_pkg::TIME_W-1:0]    rate_bps,
    output logic                         last,
    output logic                         zeros_dropped,
    input  itm_pkg::itm_cmd_t             ctl,
    output itm_pkg::itm_sts_t             sts
);

    logic [itm_pkg::IVL_W-1:0]  interval_reg;
    logic [itm_pkg::PKT_W-1:0]  limit_reg;
    logic                      zmode_reg;
    logic [itm_pkg::SPAN_W-1:0] span_pkt_reg;
    logic [itm_pkg::SPAN_W-1:0] span_fin_reg;

    logic [itm_pkg::BYTE_W-1:0] byte_reg;
    logic [itm_pkg::PKT_W-1:0]  pkt_reg;
    logic [itm_pkg::TIME_W-1:0] last_time_reg;
    logic [itm_pkg::NRES_W-1:0] nres_reg;
    logic                      cut_reg;

    logic                      cmd_reg;
    logic [itm_pkg::TIME_W-1:0] now_reg;
    logic [itm_pkg::LEN_W-1:0]  len_reg;
    logic [itm_pkg::TIME_W-1:0] end_reg;
    logic [itm_pkg::TIME_W-1:0] end_next;
    logic                      nz_reg;
    logic                      gz_reg;
    logic [itm_pkg::TIME_W-1:0] rate_pend_reg;

    logic                      out_valid_reg;
    logic [itm_pkg::TIME_W-1:0] report_time_reg;
    logic [itm_pkg::TIME_W-1:0] rate_reg;
    logic                      last_reg;
    logic                      zd_reg;

    logic [itm_pkg::BSUM_W-1:0] bnd;
    logic [itm_pkg::BSUM_W-1:0] now_ext;
    logic [itm_pkg::BSUM_W-1:0] cut_sum;
    logic [itm_pkg::SPAN_W-1:0] span_sel;
    logic                      cut_cond;
    logic [itm_pkg::BYTE_W:0]   byte_sum;
    logic [itm_pkg::BYTE_W-1:0] byte_add;
    logic [itm_pkg::TIME_W-1:0] gap;
    logic                      gap_zero;
    logic                      bytes_nz;
    logic [itm_pkg::PROD_W-1:0] product;
    logic [itm_pkg::TIME_W-1:0] jump_diff;
    logic [itm_pkg::TIME_W-1:0] jump_last;
    logic [itm_pkg::DIV_W-1:0]  div_dividend;
    logic [itm_pkg::TIME_W-1:0] div_divisor;
    logic [itm_pkg::DIV_W-1:0]  quotient;
    logic [itm_pkg::TIME_W-1:0] remainder;
    logic                      div_last;
    logic [itm_pkg::QEXT_W-1:0] q_ext;
    logic                      q_sat;
    logic [itm_pkg::TIME_W-1:0] rate_val;
    logic                      out_free;

    assign now_ext  = itm_pkg::BSUM_W'(now_reg);
    assign bnd      = itm_pkg::BSUM_W'(last_time_reg) + itm_pkg::BSUM_W'(interval_reg);
    assign span_sel = (cmd_reg == itm_pkg::CMD_FINISH) ? span_fin_reg : span_pkt_reg;
    assign cut_sum  = itm_pkg::BSUM_W'(last_time_reg) + itm_pkg::BSUM_W'(span_sel);
    assign cut_cond = zmode_reg && ((cmd_reg == itm_pkg::CMD_FINISH) ? (cut_sum < now_ext)
                                                                      : (cut_sum <= now_ext));

    assign byte_sum = (itm_pkg::BYTE_W + 1)'(byte_reg) + (itm_pkg::BYTE_W + 1)'(len_reg);
    assign byte_add = byte_sum[itm_pkg::BYTE_W] ? {itm_pkg::BYTE_W{1'b1}}
                                                : byte_sum[itm_pkg::BYTE_W-1:0];

    always_comb
    begin
        case (ctl.end_sel)
            itm_pkg::END_NOW:   end_next = now_reg;
            itm_pkg::END_BND:   end_next = bnd[itm_pkg::TIME_W-1:0];
            itm_pkg::END_CATCH: end_next = now_reg - itm_pkg::TIME_W'(interval_reg);
            default:            end_next = now_reg;
        endcase
    end

    assign gap      = (end_reg > last_time_reg) ? (end_reg - last_time_reg) : '0;
    assign gap_zero = gap == '0;
    assign bytes_nz = byte_reg != '0;
    assign product  = itm_pkg::PROD_W'({byte_reg, 3'b000})
                    * itm_pkg::PROD_W'(itm_pkg::TICKS_PER_SECOND);

    assign jump_diff    = now_reg - last_time_reg - itm_pkg::TIME_W'(cmd_reg);
    assign jump_last    = now_reg - itm_pkg::TIME_W'(cmd_reg) - remainder;
    assign div_dividend = ctl.jump_start ? itm_pkg::DIV_W'(jump_diff)
                                         : itm_pkg::DIV_W'(product);
    assign div_divisor  = ctl.jump_start ? itm_pkg::TIME_W'(interval_reg) : gap;

    itm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (ctl.rate_start | ctl.jump_start),
        .step      (ctl.div_step),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (quotient),
        .remainder (remainder),
        .last_step (div_last)
    );

    assign q_ext    = itm_pkg::QEXT_W'(quotient);
    assign q_sat    = |q_ext[itm_pkg::QEXT_W-1:itm_pkg::TIME_W];
    assign rate_val = !nz_reg ? '0
                    : (gz_reg || q_sat) ? itm_pkg::RATE_MAX
                    : q_ext[itm_pkg::TIME_W-1:0];

    assign out_free = !out_valid_reg || !out_stall;

    assign sts.cmd         = cmd_reg;
    assign sts.zmode       = zmode_reg;
    assign sts.limit_hit   = pkt_reg >= limit_reg;
    assign sts.bnd_le      = bnd <= now_ext;
    assign sts.bnd_lt      = bnd < now_ext;
    assign sts.last_lt_now = last_time_reg < now_reg;
    assign sts.cap_pkt     = nres_reg == itm_pkg::NRES_W'(itm_pkg::MAX_REPORTS);
    assign sts.cap_fin     = nres_reg == itm_pkg::NRES_W'(itm_pkg::MAX_REPORTS - 1);
    assign sts.need_div    = bytes_nz && !gap_zero;
    assign sts.div_last    = div_last;
    assign sts.out_free    = out_free;
    assign sts.cut         = cut_reg;
    assign sts.ivl_zero    = interval_reg == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg  <= itm_pkg::IVL_RESET;
            limit_reg     <= itm_pkg::LIMIT_RESET;
            zmode_reg     <= itm_pkg::ZMODE_RESET;
            byte_reg      <= '0;
            pkt_reg       <= '0;
            last_time_reg <= '0;
            nres_reg      <= '0;
            cut_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (itm_pkg::cfg_idx_t'(cfg_index))
                    itm_pkg::CFG_INTERVAL: interval_reg <= cfg_data[itm_pkg::IVL_W-1:0];
                    itm_pkg::CFG_LIMIT:    limit_reg    <= cfg_data[itm_pkg::PKT_W-1:0];
                    itm_pkg::CFG_ZMODE:    zmode_reg    <= cfg_data[0];
                    default:               ;
                endcase
            end
            if (ctl.accept)
            begin
                if (command == itm_pkg::CMD_PACKET && pkt_reg != {itm_pkg::PKT_W{1'b1}})
                begin
                    pkt_reg <= pkt_reg + 1'b1;
                end
                nres_reg <= '0;
                cut_reg  <= 1'b0;
            end
            if (ctl.add_bytes)
            begin
                byte_reg <= byte_add;
            end
            if (ctl.eval_cut)
            begin
                cut_reg <= cut_cond;
            end
            if (ctl.rep_commit)
            begin
                if (nz_reg)
                begin
                    byte_reg <= '0;
                    pkt_reg  <= '0;
                end
                last_time_reg <= end_reg;
                nres_reg      <= nres_reg + 1'b1;
            end
            if (ctl.jump_commit)
            begin
                last_time_reg <= jump_last;
            end
            if (ctl.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        span_pkt_reg <= itm_pkg::SPAN_W'(interval_reg)
                      * itm_pkg::SPAN_W'(itm_pkg::MAX_REPORTS + 1);
        span_fin_reg <= itm_pkg::SPAN_W'(interval_reg)
                      * itm_pkg::SPAN_W'(itm_pkg::MAX_REPORTS);
        if (ctl.accept)
        begin
            cmd_reg <= command;
            now_reg <= now_time;
            len_reg <= packet_bytes;
        end
        if (ctl.load_end)
        begin
            end_reg <= end_next;
        end
        if (ctl.rate_start)
        begin
            nz_reg <= bytes_nz;
            gz_reg <= gap_zero;
        end
        if (ctl.rep_commit)
        begin
            rate_pend_reg <= rate_val;
        end
        if (ctl.push)
        begin
            report_time_reg <= end_reg;
            rate_reg        <= rate_pend_reg;
            last_reg        <= ctl.push_last;
            zd_reg          <= cut_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign report_time   = report_time_reg;
    assign rate_bps      = rate_reg;
    assign last          = last_reg;
    assign zeros_dropped = zd_reg;

`ifndef SYNTHESIS
    a_nres_cap: assert property (@(posedge clk) disable iff (!rst_n)
        nres_reg <= itm_pkg::NRES_W'(itm_pkg::MAX_REPORTS))
        else $error("result count past cap");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> out_free)
        else $error("word pushed over a held output word");

    a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.rep_commit && nz_reg) |=> (byte_reg == '0 && pkt_reg == '0))
        else $error("counters not cleared by a report with bytes");
`endif

endmodule

// ===== hw/rtl/itm_ctrl.sv =====
// Controller: sequences evaluation, report runs, divisions, boundary jump and output pushes.
module itm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  itm_pkg::itm_sts_t sts,
    output itm_pkg::itm_cmd_t ctl
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_EVAL   = 9'b000000010,
        S_RSTART = 9'b000000100,
        S_DIV    = 9'b000001000,
        S_REND   = 9'b000010000,
        S_NEXT   = 9'b000100000,
        S_JSTART = 9'b001000000,
        S_JDIV   = 9'b010000000,
        S_JEND   = 9'b100000000
    } state_t;

    typedef enum logic [2:0] {
        K_LIMIT  = 3'd0,
        K_STEP_P = 3'd1,
        K_CATCH  = 3'd2,
        K_STEP_F = 3'd3,
        K_FINAL  = 3'd4
    } kind_t;

    state_t state_reg;
    state_t state_next;
    kind_t  kind_reg;
    kind_t  kind_next;
    logic   more_pkt;
    logic   more_fin;
    logic   do_jump;

    assign more_pkt = sts.bnd_le && (!sts.zmode || !sts.cap_pkt);
    assign more_fin = sts.zmode && sts.bnd_lt && !sts.cap_fin;
    assign do_jump  = sts.cut && !sts.ivl_zero;
    assign in_stall = state_reg != S_IDLE;

    always_comb
    begin
        ctl         = '0;
        ctl.end_sel = itm_pkg::END_NOW;
        state_next  = state_reg;
        kind_next   = kind_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.accept = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (sts.cmd == itm_pkg::CMD_PACKET)
                begin
                    if (sts.limit_hit)
                    begin
                        ctl.add_bytes = 1'b1;
                        ctl.load_end  = 1'b1;
                        kind_next     = K_LIMIT;
                        state_next    = S_RSTART;
                    end
                    else if (sts.bnd_le)
                    begin
                        ctl.load_end = 1'b1;
                        ctl.end_sel  = itm_pkg::END_BND;
                        ctl.eval_cut = 1'b1;
                        kind_next    = K_STEP_P;
                        state_next   = S_RSTART;
                    end
                    else
                    begin
                        ctl.add_bytes = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else if (sts.last_lt_now)
                begin
                    ctl.load_end = 1'b1;
                    state_next   = S_RSTART;
                    if (sts.bnd_lt)
                    begin
                        ctl.end_sel  = itm_pkg::END_BND;
                        ctl.eval_cut = 1'b1;
                        kind_next    = K_STEP_F;
                    end
                    else
                    begin
                        kind_next = K_FINAL;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RSTART:
            begin
                ctl.rate_start = 1'b1;
                state_next     = sts.need_div ? S_DIV : S_REND;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_REND;
                end
            end
            S_REND:
            begin
                ctl.rep_commit = 1'b1;
                state_next     = S_NEXT;
            end
            S_NEXT:
            begin
                if (sts.out_free)
                begin
                    ctl.push = 1'b1;
                    case (kind_reg)
                        K_STEP_P:
                        begin
                            if (more_pkt)
                            begin
                                ctl.load_end = 1'b1;
                                state_next   = S_RSTART;
                                if (sts.zmode)
                                begin
                                    ctl.end_sel = itm_pkg::END_BND;
                                    kind_next   = K_STEP_P;
                                end
                                else
                                begin
                                    ctl.end_sel = itm_pkg::END_CATCH;
                                    kind_next   = K_CATCH;
                                end
                            end
                            else
                            begin
                                ctl.push_last = 1'b1;
                                if (do_jump)
                                begin
                                    state_next = S_JSTART;
                                end
                                else
                                begin
                                    ctl.add_bytes = 1'b1;
                                    state_next    = S_IDLE;
                                end
                            end
                        end
                        K_STEP_F:
                        begin
                            if (more_fin)
                            begin
                                ctl.load_end = 1'b1;
                                ctl.end_sel  = itm_pkg::END_BND;
                                kind_next    = K_STEP_F;
                                state_next   = S_RSTART;
                            end
                            else if (do_jump)
                            begin
                                state_next = S_JSTART;
                            end
                            else
                            begin
                                ctl.load_end = 1'b1;
                                kind_next    = K_FINAL;
                                state_next   = S_RSTART;
                            end
                        end
                        K_CATCH:
                        begin
                            ctl.push_last = 1'b1;
                            ctl.add_bytes = 1'b1;
                            state_next    = S_IDLE;
                        end
                        default:
                        begin
                            ctl.push_last = 1'b1;
                            state_next    = S_IDLE;
                        end
                    endcase
                end
            end
            S_JSTART:
            begin
                ctl.jump_start = 1'b1;
                state_next     = S_JDIV;
            end
            S_JDIV:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_JEND;
                end
            end
            S_JEND:
            begin
                ctl.jump_commit = 1'b1;
                if (sts.cmd == itm_pkg::CMD_PACKET)
                begin
                    ctl.add_bytes = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    ctl.load_end = 1'b1;
                    kind_next    = K_FINAL;
                    state_next   = S_RSTART;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= K_FINAL;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

// ===== hw/rtl/interval_throughput_meter.sv =====
// Top level of the interval throughput meter: controller plus datapath.
//
//   channel   handshake            payload
//   in        in_valid / in_stall  command, now_time, packet_bytes
//   out       out_valid / out_stall report_time, rate_bps, last, zeros_dropped
//   cfg       cfg_wr_en            cfg_index, cfg_data
//
// A packet that makes no report, or a finish with nothing to flush, only passes through evaluation.
// A report holding bytes over a nonzero gap runs the divider (63 divider steps), any other
// report skips it; a cut zero run adds a boundary jump, which also runs the divider.
// One word at a time is in work; the divider is the shared unit that sets the rate.
// Reset clears counters, last report time and config to defaults; no clearing pass.
// A stalled output holds its word; the next report waits in the datapath until taken.
module interval_throughput_meter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [itm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [itm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         command,
    input  logic [itm_pkg::TIME_W-1:0]    now_time,
    input  logic [itm_pkg::LEN_W-1:0]     packet_bytes,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [itm_pkg::TIME_W-1:0]    report_time,
    output logic [itm_pkg::TIME_W-1:0]    rate_bps,
    output logic                         last,
    output logic                         zeros_dropped
);

    itm_pkg::itm_cmd_t ctl;
    itm_pkg::itm_sts_t sts;

    itm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .ctl      (ctl)
    );

    itm_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .now_time      (now_time),
        .packet_bytes  (packet_bytes),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .report_time   (report_time),
        .rate_bps      (rate_bps),
        .last          (last),
        .zeros_dropped (zeros_dropped),
        .ctl           (ctl),
        .sts           (sts)
    );

endmodule
